### hw/rtl/sync_length_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Property checked at every rising clk edge outside reset.
`define SLFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication checked at every rising clk edge outside reset.
`define SLFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
// No dependencies; imported by the top level and the checker.
package slfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FRAME_LEN_W = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned LENGTH_BYTES_DEF = 4;

  localparam logic [BYTE_W-1:0]      FIRST_SYNC_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0]      SECOND_SYNC_RST = 8'h55;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_RST   = 32'(128 * 1024);

  typedef enum logic [1:0] {
    PH_HUNT0 = 2'd0,
    PH_HUNT1 = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_REJECT = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC  = 2'd0,
    CFG_SECOND_SYNC = 2'd1,
    CFG_MAX_FRAME   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

endpackage

### hw/rtl/sync_length_frame_deframer_top.sv
// Two-byte sync, length-prefixed deframer: top level.
// Depends on slfd_pkg for types, register codes and reset values.

// One received byte is taken per request; a new request is taken in every
// cycle unless stalled. Each byte updates the hunt/length/payload state in
// the cycle it is accepted; a payload byte or a bad-length reject comes out
// of the output register in the next cycle. in_stall rises only while that
// output register holds a result that the sink is stalling, so throughput
// is one byte per cycle while out_stall is low. Sync and length bytes give
// no result. Register writes take effect on the next byte that uses them.
module sync_length_frame_deframer_top
  import slfd_pkg::*;
#(
  parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_kind,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic                   out_first_of_frame,
  output logic                   out_last_of_frame,
  output logic [FRAME_LEN_W-1:0] out_frame_length
);

  localparam int unsigned ASM_W = BYTE_W * LENGTH_BYTES;
  localparam int unsigned CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(LENGTH_BYTES - 1);

  // configuration
  logic [BYTE_W-1:0]      first_sync_r;
  logic [BYTE_W-1:0]      second_sync_r;
  logic [FRAME_LEN_W-1:0] max_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
      max_frame_r   <= MAX_FRAME_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_SYNC:  first_sync_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_SECOND_SYNC: second_sync_r <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_FRAME:   max_frame_r   <= cfg_wdata[FRAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       len_pos_r, len_pos_nxt;
  logic [ASM_W-1:0]       asm_r, asm_nxt;
  logic [FRAME_LEN_W-1:0] pay_cnt_r, pay_cnt_nxt;

  // output register
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_first_r;
  logic                   out_last_r;
  logic [FRAME_LEN_W-1:0] out_len_r;

  logic                   accept;
  logic                   res_valid;
  kind_t                  res_kind;
  logic [BYTE_W-1:0]      res_byte;
  logic                   res_first;
  logic                   res_last;
  logic [FRAME_LEN_W-1:0] res_len;

  logic [ASM_W-1:0]       asm_lane;
  logic [ASM_W-1:0]       asm_full;
  logic [FRAME_LEN_W-1:0] len_full;
  logic [FRAME_LEN_W-1:0] len_cur;
  logic [FRAME_LEN_W-1:0] cnt_inc;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // drop the incoming byte into its lane of the length word
  always_comb begin
    asm_lane = '0;
    for (int i = 0; i < int'(LENGTH_BYTES); i++) begin
      if (len_pos_r == CNT_W'(i)) begin
        asm_lane[i*BYTE_W +: BYTE_W] = in_rx_byte;
      end
    end
  end

  assign asm_full = asm_r | asm_lane;
  assign len_full = FRAME_LEN_W'(asm_full);
  assign len_cur  = FRAME_LEN_W'(asm_r);
  assign cnt_inc  = pay_cnt_r + FRAME_LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    len_pos_nxt = len_pos_r;
    asm_nxt     = asm_r;
    pay_cnt_nxt = pay_cnt_r;
    res_valid   = 1'b0;
    res_kind    = KIND_DATA;
    res_byte    = '0;
    res_first   = 1'b0;
    res_last    = 1'b0;
    res_len     = len_cur;
    if (accept) begin
      case (phase_r)
        PH_HUNT0: begin
          if (in_rx_byte == first_sync_r) phase_nxt = PH_HUNT1;
        end
        PH_HUNT1: begin
          // second sync wins over a repeated first sync
          if (in_rx_byte == second_sync_r) begin
            phase_nxt   = PH_LEN;
            len_pos_nxt = '0;
            asm_nxt     = '0;
          end else if (in_rx_byte != first_sync_r) begin
            phase_nxt = PH_HUNT0;
          end
        end
        PH_LEN: begin
          asm_nxt = asm_full;
          if (len_pos_r == LAST_POS) begin
            len_pos_nxt = '0;
            if (len_full == '0 || len_full > max_frame_r) begin
              phase_nxt = PH_HUNT0;
              res_valid = 1'b1;
              res_kind  = KIND_REJECT;
              res_len   = len_full;
            end else begin
              phase_nxt   = PH_DATA;
              pay_cnt_nxt = '0;
            end
          end else begin
            len_pos_nxt = len_pos_r + CNT_W'(1);
          end
        end
        PH_DATA: begin
          pay_cnt_nxt = cnt_inc;
          res_valid   = 1'b1;
          res_byte    = in_rx_byte;
          res_first   = (pay_cnt_r == '0);
          res_last    = (cnt_inc == len_cur);
          if (cnt_inc == len_cur) phase_nxt = PH_HUNT0;
        end
        default: phase_nxt = PH_HUNT0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_pos_r <= '0;
      asm_r     <= '0;
      pay_cnt_r <= '0;
    end else begin
      len_pos_r <= len_pos_nxt;
      asm_r     <= asm_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

  // hold a stalled result, load a new one whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_first_r <= res_first;
      out_last_r  <= res_last;
      out_len_r   <= res_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_payload_byte   = out_byte_r;
  assign out_first_of_frame = out_first_r;
  assign out_last_of_frame  = out_last_r;
  assign out_frame_length   = out_len_r;

endmodule

### hw/rtl/slfd_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on slfd_pkg and the assertion macros header.
`include "sync_length_frame_deframer_top_defines.svh"

module slfd_checker
  import slfd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_kind,
  input logic [BYTE_W-1:0]      out_payload_byte,
  input logic                   out_first_of_frame,
  input logic                   out_last_of_frame,
  input logic [FRAME_LEN_W-1:0] out_frame_length
);

  // a stalled result stays put
  `SLFD_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_frame_length) && $stable(out_kind) &&
      $stable(out_first_of_frame) && $stable(out_last_of_frame),
    "stalled result changed")

  // reject results carry no byte and no frame marks
  `SLFD_ASSERT_IMP(a_reject_clean,
    out_valid && out_kind == KIND_REJECT,
    out_payload_byte == '0 && !out_first_of_frame && !out_last_of_frame,
    "reject result carries payload fields")

  // input is held off only while a result is stuck at the output
  `SLFD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a stalled result")

  // a fresh result always follows an accepted request
  `SLFD_ASSERT(a_no_invent, $rose(out_valid) |-> $past(in_valid && !in_stall),
    "result without a request")

endmodule

bind sync_length_frame_deframer_top slfd_checker u_slfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_payload_byte   (out_payload_byte),
  .out_first_of_frame (out_first_of_frame),
  .out_last_of_frame  (out_last_of_frame),
  .out_frame_length   (out_frame_length)
);

### verif/sync_length_frame_deframer_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the sync/length frame deframer: tracks register writes and
// accepted bytes, predicts each payload or reject result and compares it.
// Depends on slfd_pkg for widths, phase, kind and register index codes.
module sync_length_frame_deframer_checker
  import slfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_rx_byte,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_kind,
  input  logic [BYTE_W-1:0]      out_payload_byte,
  input  logic                   out_first_of_frame,
  input  logic                   out_last_of_frame,
  input  logic [FRAME_LEN_W-1:0] out_frame_length,
  output int                     mismatches,
  output int                     awaited
);

  typedef struct packed {
    kind_t                  kind;
    logic [BYTE_W-1:0]      data;
    logic                   first;
    logic                   last;
    logic [FRAME_LEN_W-1:0] length;
  } frame_result_t;

  logic [BYTE_W-1:0]      sync_a;
  logic [BYTE_W-1:0]      sync_b;
  logic [FRAME_LEN_W-1:0] len_limit;

  phase_t                 hunt_state;
  logic [1:0]             len_pos;
  logic [FRAME_LEN_W-1:0] len_acc;
  logic [FRAME_LEN_W-1:0] bytes_out;

  frame_result_t frame_results[$];

  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    case (hunt_state)
      PH_HUNT0: begin
        if (b == sync_a) hunt_state = PH_HUNT1;
      end
      PH_HUNT1: begin
        // second sync wins over a repeated first sync
        if (b == sync_b) begin
          hunt_state = PH_LEN;
          len_pos    = '0;
          len_acc    = '0;
        end else if (b != sync_a) begin
          hunt_state = PH_HUNT0;
        end
      end
      PH_LEN: begin
        len_acc = len_acc | (FRAME_LEN_W'(b) << (8 * len_pos));
        if (int'(len_pos) + 1 >= LENGTH_BYTES_DEF) begin
          len_pos = '0;
          if (len_acc == '0 || len_acc > len_limit) begin
            hunt_state = PH_HUNT0;
            r.kind   = KIND_REJECT;
            r.data   = '0;
            r.first  = 1'b0;
            r.last   = 1'b0;
            r.length = len_acc;
            frame_results.push_back(r);
          end else begin
            hunt_state = PH_DATA;
            bytes_out  = '0;
          end
        end else begin
          len_pos = len_pos + 2'd1;
        end
      end
      default: begin
        r.kind    = KIND_DATA;
        r.data    = b;
        r.first   = (bytes_out == '0);
        bytes_out = bytes_out + 1;
        r.last    = (bytes_out == len_acc);
        r.length  = len_acc;
        if (r.last) hunt_state = PH_HUNT0;
        frame_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    if (frame_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind=%0b byte=%02h first=%0b last=%0b len=%08h",
                 $realtime, out_kind, out_payload_byte, out_first_of_frame,
                 out_last_of_frame, out_frame_length);
    end else begin
      want = frame_results.pop_front();
      if (want.kind !== out_kind || want.data !== out_payload_byte ||
          want.first !== out_first_of_frame || want.last !== out_last_of_frame ||
          want.length !== out_frame_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected kind=%0b byte=%02h first=%0b last=%0b len=%08h,",
                   $realtime, want.kind, want.data, want.first, want.last, want.length);
          $display("  got kind=%0b byte=%02h first=%0b last=%0b len=%08h",
                   out_kind, out_payload_byte, out_first_of_frame, out_last_of_frame,
                   out_frame_length);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_a     = FIRST_SYNC_RST;
      sync_b     = SECOND_SYNC_RST;
      len_limit  = MAX_FRAME_RST;
      hunt_state = PH_HUNT0;
      len_pos    = '0;
      len_acc    = '0;
      bytes_out  = '0;
      frame_results.delete();
    end else begin
      // a byte accepted at this edge still sees the old register values
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_SYNC:  sync_a    = cfg_wdata[BYTE_W-1:0];
          CFG_SECOND_SYNC: sync_b    = cfg_wdata[BYTE_W-1:0];
          CFG_MAX_FRAME:   len_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_result();
    end
    awaited = frame_results.size();
  end

endmodule

### verif/sync_length_frame_deframer_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the sync/length frame deframer: clock, reset, register
// setup, byte stimulus, sink stalls, watchdog and verdict.
// Depends on slfd_pkg, the deframer top level and the deframer checker.
module sync_length_frame_deframer_top_test;
  import slfd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 75;
  localparam int PHASE_COUNT  = 8;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_rx_byte;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_kind;
  logic [BYTE_W-1:0]      out_payload_byte;
  logic                   out_first_of_frame;
  logic                   out_last_of_frame;
  logic [FRAME_LEN_W-1:0] out_frame_length;

  int mismatches;
  int awaited;
  int idle_cycles;
  int items_sent;
  int sender_gap_pct = 15;
  int sink_stall_pct = 15;
  bit hold_request;

  // register values last written, used to shape frames
  logic [BYTE_W-1:0]      cur_first;
  logic [BYTE_W-1:0]      cur_second;
  logic [FRAME_LEN_W-1:0] cur_max;

  logic [BYTE_W-1:0] reset_frames [16] = '{
    FIRST_SYNC_RST, FIRST_SYNC_RST, SECOND_SYNC_RST, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF,
    FIRST_SYNC_RST, SECOND_SYNC_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    FIRST_SYNC_RST, 8'h00
  };
  logic [BYTE_W-1:0] split_head [4] = '{8'h3C, 8'h3C, 8'h02, 8'h00};
  logic [BYTE_W-1:0] split_tail [8] = '{
    8'h00, 8'h00, 8'h3C, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00
  };

  sync_length_frame_deframer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_frame_length   (out_frame_length)
  );

  sync_length_frame_deframer_checker frame_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_frame_length   (out_frame_length),
    .mismatches         (mismatches),
    .awaited            (awaited)
  );

  always #5 clk = ~clk;

  // sink: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
    $display("sync_length_frame_deframer_top_test NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off until every result has come out, plus the output register delay
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_FIRST_SYNC:  cur_first  = value[BYTE_W-1:0];
      CFG_SECOND_SYNC: cur_second = value[BYTE_W-1:0];
      CFG_MAX_FRAME:   cur_max    = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                               input logic [FRAME_LEN_W-1:0] limit);
    write_reg(CFG_FIRST_SYNC, {24'($urandom), first});
    write_reg(CFG_SECOND_SYNC, {24'($urandom), second});
    write_reg(CFG_MAX_FRAME, limit);
    // a write to the unused index must be dropped
    write_reg(CFG_UNUSED, $urandom);
  endtask

  task automatic send_frame(input logic [FRAME_LEN_W-1:0] length, input bit repeat_first);
    send_byte(cur_first);
    if (repeat_first && cur_first != cur_second) send_byte(cur_first);
    send_byte(cur_second);
    for (int i = 0; i < LENGTH_BYTES_DEF; i++) send_byte(length[8*i +: 8]);
    if (length != '0 && length <= cur_max)
      for (int i = 0; i < int'(length); i++) send_byte(BYTE_W'($urandom));
  endtask

  task automatic random_request();
    int                     pick;
    int                     cap;
    logic [BYTE_W-1:0]      b;
    logic [FRAME_LEN_W-1:0] span;
    bit                     rep;
    pick = $urandom_range(0, 99);
    rep  = ($urandom_range(0, 3) == 0);
    if (pick < 6) begin
      // noise that never looks like a frame start
      repeat ($urandom_range(1, 3)) begin
        b = BYTE_W'($urandom);
        if (b == cur_first) b = ~b;
        send_byte(b);
      end
    end else if (pick < 10) begin
      // first sync followed by a byte that drops back to hunting
      send_byte(cur_first);
      b = BYTE_W'($urandom);
      while (b == cur_first || b == cur_second) b = BYTE_W'($urandom);
      send_byte(b);
    end else if (pick < 18) begin
      send_frame('0, rep);
    end else if (pick < 26 && cur_max != '1) begin
      span = 32'hFFFF_FFFF - cur_max;
      if ($urandom_range(0, 1)) send_frame(cur_max + 1, rep);
      else send_frame(cur_max + 1 + ($urandom % span), rep);
    end else if (cur_max == '0) begin
      send_frame(FRAME_LEN_W'($urandom_range(1, 16)), rep);
    end else begin
      cap = (cur_max < 12) ? int'(cur_max) : 12;
      if (cur_max <= 12 && $urandom_range(0, 2) == 0) send_frame(cur_max, rep);
      else send_frame(FRAME_LEN_W'($urandom_range(1, cap)), rep);
    end
  endtask

  initial begin
    int               phase_end;
    logic [BYTE_W-1:0] f;
    logic [BYTE_W-1:0] s;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_FIRST_SYNC;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    items_sent = 0;
    cur_first  = FIRST_SYNC_RST;
    cur_second = SECOND_SYNC_RST;
    cur_max    = MAX_FRAME_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: repeated first sync, one-byte frame, all-ones reject, broken sync
    foreach (reset_frames[i]) send_byte(reset_frames[i]);

    // equal sync bytes; tighten the limit while the length is half gathered
    wait_drained();
    load_settings(8'h3C, 8'h3C, 32'd2);
    foreach (split_head[i]) send_byte(split_head[i]);
    wait_drained();
    write_reg(CFG_MAX_FRAME, 32'd1);
    foreach (split_tail[i]) send_byte(split_tail[i]);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      f = BYTE_W'($urandom);
      s = BYTE_W'($urandom);
      sender_gap_pct = 15;
      sink_stall_pct = 15;
      case (p)
        0: load_settings(FIRST_SYNC_RST, SECOND_SYNC_RST, MAX_FRAME_RST);
        1: begin
          load_settings(f, s, FRAME_LEN_W'($urandom_range(1, 16)));
          hold_request = 1'b1;
        end
        2: begin
          load_settings(f, f, 32'd8);
          sender_gap_pct = 0;
          sink_stall_pct = 0;
        end
        3: load_settings(8'h00, 8'hFF, 32'd0);
        4: load_settings(8'hFF, 8'h00, 32'hFFFF_FFFF);
        5: load_settings(f, s, 32'd1);
        6: load_settings(f, s, $urandom);
        default: load_settings(f, s, 32'd5);
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_request();
    end

    wait_drained();
    if (mismatches == 0 && awaited == 0) begin
      $display("sync_length_frame_deframer_top_test OK");
    end else begin
      $display("sync_length_frame_deframer_top_test NOT OK");
    end
    $finish;
  end

endmodule

### sync_length_frame_deframer_top.f
+incdir+hw/rtl
hw/rtl/slfd_pkg.sv
hw/rtl/sync_length_frame_deframer_top.sv
hw/rtl/slfd_checker.sv
verif/sync_length_frame_deframer_checker.sv
verif/sync_length_frame_deframer_top_test.sv
